FILE: sv/dds_pkg.sv
// dds_pkg: widths, derived sizes and state type for the decimal digit splitter
// no dependencies; used by decimal_digit_split_and_sum
package dds_pkg;

    // significant input bits
    localparam int VALUE_BITS = 63;

    // decimal digits needed for VALUE_BITS bits (log10(2) ~ 0.30103)
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

    localparam int DIGIT_BITS = 4;
    localparam int BCD_BITS   = NUM_DIGITS * DIGIT_BITS;
    localparam int SUM_BITS   = 8;

    // counter covers both the bit count and the digit count
    localparam int CNT_MAX  = (VALUE_BITS > NUM_DIGITS) ? VALUE_BITS : NUM_DIGITS;
    localparam int CNT_BITS = $clog2(CNT_MAX + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

endpackage

FILE: sv/decimal_digit_split_and_sum.sv
// Each item runs a shift-and-add-3 conversion, one bit per cycle, then its digit slots are
// shifted out msd first while the output can take a beat; leading zero slots are dropped
// without a beat. A new item is not accepted until the last digit beat has been issued,
// since the serial converter and the digit-by-digit output shifter are not overlapped.
// Synchronous active-low reset clears state and output valid; payload registers are not
// reset.
module decimal_digit_split_and_sum (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [dds_pkg::VALUE_BITS-1:0]     i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [dds_pkg::DIGIT_BITS-1:0]     o_digit,
    output logic [dds_pkg::SUM_BITS-1:0]       o_digit_sum,
    output logic                               o_last
);
    import dds_pkg::*;

    t_state                 r_state, n_state;
    logic [VALUE_BITS-1:0]  r_bin, n_bin;
    logic [BCD_BITS-1:0]    r_bcd, n_bcd;
    logic [CNT_BITS-1:0]    r_cnt, n_cnt;
    logic [SUM_BITS-1:0]    r_sum, n_sum;
    logic                   r_started, n_started;
    logic                   r_out_valid, n_out_valid;
    logic [DIGIT_BITS-1:0]  r_digit, n_digit;
    logic [SUM_BITS-1:0]    r_dsum, n_dsum;
    logic                   r_last, n_last;

    logic [BCD_BITS-1:0]    adj_bcd;
    logic [DIGIT_BITS-1:0]  top_digit;
    logic                   can_step;
    logic                   is_final;
    logic                   skip_zero;
    logic                   conv_done;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[i*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
                adj_bcd[i*DIGIT_BITS +: DIGIT_BITS] =
                    r_bcd[i*DIGIT_BITS +: DIGIT_BITS] + DIGIT_BITS'(3);
            end else begin
                adj_bcd[i*DIGIT_BITS +: DIGIT_BITS] = r_bcd[i*DIGIT_BITS +: DIGIT_BITS];
            end
        end
    end

    assign top_digit = r_bcd[BCD_BITS-1 -: DIGIT_BITS];
    assign can_step  = !r_out_valid || i_out_ready;
    assign is_final  = (r_cnt == CNT_BITS'(1));
    assign skip_zero = (top_digit == '0) && !r_started && !is_final;
    assign conv_done = (r_cnt == CNT_BITS'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (conv_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (can_step && is_final) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and output register
    always_comb begin
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_started   = r_started;
        n_out_valid = r_out_valid && !i_out_ready;
        n_digit     = r_digit;
        n_dsum      = r_dsum;
        n_last      = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_bin     = i_value;
                    n_bcd     = '0;
                    n_cnt     = CNT_BITS'(VALUE_BITS);
                    n_sum     = '0;
                    n_started = 1'b0;
                end
            end
            S_CONV: begin
                n_bcd = {adj_bcd[BCD_BITS-2:0], r_bin[VALUE_BITS-1]};
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                if (conv_done) begin
                    n_cnt = CNT_BITS'(NUM_DIGITS);
                end else begin
                    n_cnt = r_cnt - CNT_BITS'(1);
                end
            end
            S_EMIT: begin
                if (can_step) begin
                    n_bcd = {r_bcd[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
                    n_cnt = r_cnt - CNT_BITS'(1);
                    if (!skip_zero) begin
                        n_started   = 1'b1;
                        n_sum       = r_sum + SUM_BITS'(top_digit);
                        n_out_valid = 1'b1;
                        n_digit     = top_digit;
                        n_last      = is_final;
                        n_dsum      = is_final ? (r_sum + SUM_BITS'(top_digit)) : '0;
                    end
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_started   <= n_started;
            r_cnt       <= n_cnt;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_sum   <= n_sum;
        r_digit <= n_digit;
        r_dsum  <= n_dsum;
        r_last  <= n_last;
    end

    // ports
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_digit     = r_digit;
    assign o_digit_sum = r_dsum;
    assign o_last      = r_last;

endmodule

FILE: tb/sv/decimal_digit_split_and_sum_tb.sv
// decimal_digit_split_and_sum_tb: self-checking bench for the decimal digit splitter
// drives binary values, predicts digit beats (msd first, sum on last), checks each beat
// depends on dds_pkg and decimal_digit_split_and_sum
module decimal_digit_split_and_sum_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dds_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 100;

    typedef logic [VALUE_BITS-1:0] t_value;

    typedef struct packed {
        logic [DIGIT_BITS-1:0] digit;
        logic [SUM_BITS-1:0]   digit_sum;
        logic                  last;
    } t_digit_beat;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_value                i_value     = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [DIGIT_BITS-1:0] o_digit;
    logic [SUM_BITS-1:0]   o_digit_sum;
    logic                  o_last;

    t_value      pend_values[$];
    t_digit_beat exp_digits[$];
    t_digit_beat want;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_req_cnt  = 0;
    int  hold_seen     = 0;
    int  hold_left     = 0;
    int  stall_cycles  = 0;
    int  err_cnt       = 0;
    logic in_beat_taken = 1'b0;

    decimal_digit_split_and_sum uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_digit     (o_digit),
        .o_digit_sum (o_digit_sum),
        .o_last      (o_last)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        err_cnt++;
    endtask

    // split a value into decimal digits, queue them msd first, sum on the last one
    task automatic predict_digits(input t_value v);
        logic [63:0]           rest;
        logic [DIGIT_BITS-1:0] lsd_first[$];
        int unsigned           total;
        t_digit_beat           b;
        rest  = 64'(v);
        total = 0;
        do begin
            lsd_first.push_back(DIGIT_BITS'(rest % 10));
            total += int'(rest % 10);
            rest  = rest / 10;
        end while (rest != 0);
        for (int k = lsd_first.size() - 1; k >= 0; k--) begin
            b.digit     = lsd_first[k];
            b.last      = (k == 0);
            b.digit_sum = (k == 0) ? SUM_BITS'(total) : '0;
            exp_digits.push_back(b);
        end
    endtask

    // mostly values of random bit length, some near powers of ten, some full width
    function automatic t_value rand_value();
        logic [63:0] raw;
        logic [63:0] p10;
        int          len;
        int          k;
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return t_value'(raw);
            1, 2: begin
                k   = $urandom_range(18);
                p10 = 64'd1;
                repeat (k) p10 = p10 * 10;
                p10 = p10 + $urandom_range(2) - 1;
                return t_value'(p10);
            end
            default: begin
                len = $urandom_range(1, VALUE_BITS);
                return t_value'(raw >> (64 - len));
            end
        endcase
    endfunction

    // sleep until the sender is empty and every digit beat has come back
    task automatic wait_all_done();
        do begin
            @(posedge i_clk);
            #1;
        end while (pend_values.size() != 0 || i_in_valid || exp_digits.size() != 0);
    endtask

    // input driver: new beat at the falling edge, held until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_beat_taken) begin
            if (pend_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_value    <= pend_values.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output ready: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_seen != hold_req_cnt) begin
            hold_seen   <= hold_req_cnt;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on each input beat, check each digit beat
    always @(posedge i_clk) begin
        in_beat_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                predict_digits(i_value);
            if (o_out_valid && i_out_ready) begin
                if (exp_digits.size() == 0) begin
                    report_mismatch($sformatf("digit beat %0d last %0b with nothing pending",
                                              o_digit, o_last));
                end else begin
                    want = exp_digits.pop_front();
                    if (o_digit !== want.digit)
                        report_mismatch($sformatf("digit %0d, want %0d", o_digit, want.digit));
                    if (o_digit_sum !== want.digit_sum)
                        report_mismatch($sformatf("digit_sum %0d, want %0d",
                                                  o_digit_sum, want.digit_sum));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %b, want %b", o_last, want.last));
                end
            end
        end
    end

    // watchdog: too long without any beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero, digit boundaries, all nines, largest digit sum, full width
        send_idle_pct = 30;
        recv_idle_pct = 30;
        pend_values.push_back(t_value'(64'd0));
        pend_values.push_back(t_value'(64'd1));
        pend_values.push_back(t_value'(64'd9));
        pend_values.push_back(t_value'(64'd10));
        pend_values.push_back(t_value'(64'd99));
        pend_values.push_back(t_value'(64'd100));
        pend_values.push_back(t_value'(64'd12345));
        pend_values.push_back(t_value'(64'd999999999));
        pend_values.push_back(t_value'(64'd1000000000000000000));
        pend_values.push_back(t_value'(64'd999999999999999999));
        pend_values.push_back(t_value'(64'd1000000000000000001));
        pend_values.push_back(t_value'(64'd8999999999999999999));
        pend_values.push_back(t_value'(64'd9199999999999999999));
        pend_values.push_back('1);
        pend_values.push_back('1 - t_value'(1));
        pend_values.push_back(t_value'(1) << (VALUE_BITS - 1));
        pend_values.push_back(t_value'(64'h2AAA_AAAA_AAAA_AAAA));
        pend_values.push_back(t_value'(64'h5555_5555_5555_5555));
        pend_values.push_back(t_value'(64'd7));
        pend_values.push_back(t_value'(64'd90));
        wait_all_done();

        // sender idles lightly, receiver heavily, with one long hold-off mid-phase
        send_idle_pct = 20;
        recv_idle_pct = 62;
        repeat (70) pend_values.push_back(rand_value());
        hold_req_cnt++;
        repeat (70) pend_values.push_back(rand_value());
        wait_all_done();

        // the other way round
        send_idle_pct = 62;
        recv_idle_pct = 20;
        repeat (140) pend_values.push_back(rand_value());
        wait_all_done();

        // back to back on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (130) pend_values.push_back(rand_value());
        wait_all_done();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (exp_digits.size() != 0)
            report_mismatch($sformatf("%0d digit beats never came", exp_digits.size()));
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
sv/dds_pkg.sv
sv/decimal_digit_split_and_sum.sv
tb/sv/decimal_digit_split_and_sum_tb.sv
